### sv/fprd_pkg.sv
// Shared types for the fixed-point restoring divider.
package fprd_pkg;

	typedef struct packed {
		logic valid;
		logic zero;
	} fprd_flags_t;

endpackage

### sv/fprd_cell.sv
// One quotient-bit stage of the restoring divider array.
module fprd_cell
	import fprd_pkg::*;
#(
	parameter int unsigned INT_BITS  = 16,
	parameter int unsigned DEN_BITS  = 8,
	parameter int unsigned FRAC_BITS = 8,
	parameter int unsigned BIT       = 23
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  fprd_flags_t                   in_flags,
	input  logic [INT_BITS-1:0]           in_num,
	input  logic [DEN_BITS-1:0]           in_den,
	input  logic [DEN_BITS-1:0]           in_rem,
	input  logic [INT_BITS+FRAC_BITS-1:0] in_quo,
	output fprd_flags_t                   flags_q,
	output logic [INT_BITS-1:0]           num_q,
	output logic [DEN_BITS-1:0]           den_q,
	output logic [DEN_BITS-1:0]           rem_q,
	output logic [INT_BITS+FRAC_BITS-1:0] quo_q
);

	localparam int unsigned QUO_BITS = INT_BITS + FRAC_BITS;

	logic                dbit;
	logic [DEN_BITS:0]   rem_sh;
	logic [DEN_BITS:0]   rem_sub;
	logic                qbit;
	logic [DEN_BITS-1:0] rem_next;

	// dividend is numerator shifted up by FRAC_BITS
	generate
		if (BIT >= FRAC_BITS) begin : g_num_bit
			assign dbit = in_num[BIT-FRAC_BITS];
		end else begin : g_zero_bit
			assign dbit = 1'b0;
		end
	endgenerate

	assign rem_sh   = {in_rem, dbit};
	assign rem_sub  = rem_sh - {1'b0, in_den};
	assign qbit     = (rem_sh >= {1'b0, in_den});
	assign rem_next = qbit ? rem_sub[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (go) begin
			flags_q <= in_flags;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= in_num;
			den_q <= in_den;
			rem_q <= rem_next;
			quo_q <= {in_quo[QUO_BITS-2:0], qbit};
		end
	end

endmodule

### sv/fixed_point_restoring_divider.sv
// Top level: pipelined fixed-point restoring divider, one quotient bit per cell.
//
// channel  dir  tdata (low bit up)                 tuser
// s_*      in   numerator, denominator             -
// m_*      out  ratio_fixed, leftover              zero_divide
//
// The pipeline holds one cell per quotient bit.
// One transfer per cycle in and out when the output is taken.
// Each cell advances when it is empty or its successor advances, so bubbles
// collapse and inputs are still taken while a result waits.
// Reset clears the valid flags of all cells; no clearing pass.
// Zero denominator: quotient all ones, leftover zero, zero_divide set.
module fixed_point_restoring_divider
	import fprd_pkg::*;
#(
	parameter int unsigned INT_BITS  = 16,
	parameter int unsigned DEN_BITS  = 8,
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// numerator, denominator
	input  logic [((INT_BITS+DEN_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// ratio_fixed, leftover
	output logic [((INT_BITS+FRAC_BITS+DEN_BITS+7)/8)*8-1:0] m_tdata,
	// zero_divide
	output logic m_tuser
);

	localparam int unsigned QUO_BITS = INT_BITS + FRAC_BITS;

	fprd_flags_t                flags [QUO_BITS+1];
	logic [INT_BITS-1:0]        num   [QUO_BITS+1];
	logic [DEN_BITS-1:0]        den   [QUO_BITS+1];
	logic [DEN_BITS-1:0]        rem   [QUO_BITS+1];
	logic [QUO_BITS-1:0]        quo   [QUO_BITS+1];
	logic [QUO_BITS:0]          go;
	logic [QUO_BITS-1:0]        valid_vec;
	logic [DEN_BITS-1:0]        in_den;

	assign in_den       = s_tdata[INT_BITS+DEN_BITS-1:INT_BITS];
	assign flags[0]     = '{valid: s_tvalid, zero: (in_den == '0)};
	assign num[0]       = s_tdata[INT_BITS-1:0];
	assign den[0]       = in_den;
	assign rem[0]       = '0;
	assign quo[0]       = '0;

	assign go[QUO_BITS] = m_tready;

	genvar k;
	generate
		for (k = 0; k < QUO_BITS; k++) begin : g_cell
			assign go[k]        = !flags[k+1].valid || go[k+1];
			assign valid_vec[k] = flags[k+1].valid;
			fprd_cell #(
				.INT_BITS  (INT_BITS),
				.DEN_BITS  (DEN_BITS),
				.FRAC_BITS (FRAC_BITS),
				.BIT       (QUO_BITS - 1 - k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.go       (go[k]),
				.in_flags (flags[k]),
				.in_num   (num[k]),
				.in_den   (den[k]),
				.in_rem   (rem[k]),
				.in_quo   (quo[k]),
				.flags_q  (flags[k+1]),
				.num_q    (num[k+1]),
				.den_q    (den[k+1]),
				.rem_q    (rem[k+1]),
				.quo_q    (quo[k+1])
			);
		end
	endgenerate

	assign s_tready = go[0];
	assign m_tvalid = flags[QUO_BITS].valid;
	assign m_tuser  = flags[QUO_BITS].zero;

	always_comb begin
		m_tdata = '0;
		m_tdata[QUO_BITS-1:0] = quo[QUO_BITS];
		m_tdata[QUO_BITS+DEN_BITS-1:QUO_BITS] = flags[QUO_BITS].zero ? '0 : rem[QUO_BITS];
	end

`ifndef ASSERT_OFF
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_tdata[QUO_BITS-1:0] == '1) &&
			(m_tdata[QUO_BITS+DEN_BITS-1:QUO_BITS] == '0)))
		else $error("zero divide result malformed");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (rem[QUO_BITS] < den[QUO_BITS]))
		else $error("remainder not below denominator");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&valid_vec))
		else $error("input stalled with an empty cell");
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec == '0) |-> s_tready)
		else $error("empty pipeline not ready");
`endif

endmodule
